/* sv/assert_macros.svh */
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PPT_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/ppt_pkg.sv */
package ppt_pkg;

   localparam int DATA_BITS        = 32;
   localparam int TIMER_VALUE_BITS = 16;
   localparam int TIMER_HIGH_BITS  = 16;
   localparam int TIMEOUT_BITS     = 16;
   localparam int OP_BITS          = 2;
   localparam int CSR_INDEX_BITS   = 2;

   localparam int DEF_TIMER_BITS   = 16;

   localparam int DIV_STEPS        = DATA_BITS;
   localparam int STEP_BITS        = $clog2(DIV_STEPS);

   localparam int REQ_TDATA_BITS   = 16;
   localparam int REQ_TUSER_BITS   = OP_BITS;
   localparam int RSP_TDATA_BITS   = 3 * DATA_BITS;
   localparam int RSP_TUSER_BITS   = 2;

   localparam logic [DATA_BITS-1:0]    RST_MIN_INTERVAL  = 32'd250;
   localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT_LIMIT = 16'd20;
   localparam logic [DATA_BITS-1:0]    RST_SPEED_SCALE   = 32'd37500000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTERVAL  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_SCALE   = 2'd2;

   typedef enum logic [OP_BITS-1:0] {
      OP_FETCH    = 2'd0,
      OP_OVERFLOW = 2'd1,
      OP_PULSE    = 2'd2
   } op_type;

   typedef struct packed {
      logic fetch;
      logic overflow;
      logic capture;
      logic evaluate;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic divide;
   } status_type;

endpackage

/* sv/ppt_ctrl.sv */
module ppt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ppt_pkg::op_type     req_op,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  ppt_pkg::status_type status,
   output ppt_pkg::cmd_type    cmd
);
   import ppt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   state_type            state_ff, state_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 accept;

   always_comb begin
      req_tready    = (state_ff == ST_IDLE) && (!rsp_tvalid_ff || rsp_tready);
      accept        = req_tvalid && req_tready;
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_FETCH: begin
                     cmd.fetch     = 1'b1;
                     rsp_tvalid_in = 1'b1;
                  end
                  OP_OVERFLOW: cmd.overflow = 1'b1;
                  OP_PULSE: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_EVAL;
                  end
                  default: ;
               endcase
            end
         end
         ST_EVAL: begin
            cmd.evaluate = 1'b1;
            step_in      = '0;
            state_in     = status.divide ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         step_ff       <= step_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

/* sv/ppt_dp.sv */
module ppt_dp #(
   parameter int TIMER_BITS = ppt_pkg::DEF_TIMER_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [ppt_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ppt_pkg::DATA_BITS-1:0]          csr_data,
   input  logic [ppt_pkg::TIMER_VALUE_BITS-1:0]   timer_value,
   input  ppt_pkg::cmd_type                       cmd,
   output ppt_pkg::status_type                    status,
   output logic                                   new_value,
   output logic                                   is_stopped,
   output logic [ppt_pkg::DATA_BITS-1:0]          period_ticks,
   output logic [ppt_pkg::DATA_BITS-1:0]          speed,
   output logic [ppt_pkg::DATA_BITS-1:0]          held_speed
);
   import ppt_pkg::*;

   localparam int LowBits  = (TIMER_BITS < TIMER_VALUE_BITS) ? TIMER_BITS : TIMER_VALUE_BITS;
   localparam logic [TIMER_VALUE_BITS-1:0] LowMask =
      TIMER_VALUE_BITS'((64'd1 << LowBits) - 64'd1);

   // configuration
   logic [DATA_BITS-1:0]    min_interval_ff;
   logic [TIMEOUT_BITS-1:0] timeout_limit_ff;
   logic [DATA_BITS-1:0]    speed_scale_ff;

   // tachometer state
   logic [TIMER_HIGH_BITS-1:0] timer_high_ff, timer_high_in;
   logic [DATA_BITS-1:0]       ref_time_ff, ref_time_in;
   logic                       first_mode_ff, first_mode_in;
   logic                       waiting_ff, waiting_in;
   logic [TIMEOUT_BITS-1:0]    ovf_count_ff, ovf_count_in;
   logic [DATA_BITS-1:0]       pend_period_ff, pend_period_in;
   logic [DATA_BITS-1:0]       pend_speed_ff, pend_speed_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       pend_stop_ff, pend_stop_in;
   logic [DATA_BITS-1:0]       latched_ff, latched_in;

   // pulse and divider working registers
   logic [DATA_BITS-1:0] stamp_ff, interval_ff;
   logic [DATA_BITS-1:0] rem_ff, quot_ff, divisor_ff;

   // response payload
   logic                 out_new_ff, out_stop_ff;
   logic [DATA_BITS-1:0] out_period_ff, out_speed_ff, out_held_ff;

   logic [DATA_BITS-1:0]    stamp;
   logic [TIMEOUT_BITS-1:0] ovf_next;
   logic [DATA_BITS+1:0]    trial;

   // a shift by the full width leaves no high part
   assign stamp    = (DATA_BITS'(timer_high_ff) << TIMER_BITS) |
                     DATA_BITS'(timer_value & LowMask);
   assign ovf_next = ovf_count_ff + TIMEOUT_BITS'(1);

   // one restoring step: borrow in the top bit means the divisor did not fit
   assign trial = {1'b0, rem_ff, quot_ff[DATA_BITS-1]} - {2'b00, divisor_ff};

   assign status.divide = !first_mode_ff && (interval_ff >= min_interval_ff);

   always_comb begin
      timer_high_in  = timer_high_ff;
      ref_time_in    = ref_time_ff;
      first_mode_in  = first_mode_ff;
      waiting_in     = waiting_ff;
      ovf_count_in   = ovf_count_ff;
      pend_period_in = pend_period_ff;
      pend_speed_in  = pend_speed_ff;
      pend_valid_in  = pend_valid_ff;
      pend_stop_in   = pend_stop_ff;
      latched_in     = latched_ff;

      if (cmd.overflow) begin
         timer_high_in = timer_high_ff + TIMER_HIGH_BITS'(1);
         if (waiting_ff) begin
            ovf_count_in = ovf_next;
            if (ovf_next >= timeout_limit_ff) begin
               first_mode_in = 1'b1;
               waiting_in    = 1'b0;
               ovf_count_in  = '0;
               pend_stop_in  = 1'b1;
               pend_valid_in = 1'b1;
            end
         end
      end

      if (cmd.evaluate && first_mode_ff) begin
         first_mode_in = 1'b0;
         ref_time_in   = stamp_ff;
         waiting_in    = 1'b1;
         ovf_count_in  = '0;
         pend_stop_in  = 1'b0;
      end

      if (cmd.commit) begin
         pend_period_in = interval_ff;
         pend_speed_in  = quot_ff;
         pend_valid_in  = 1'b1;
         pend_stop_in   = 1'b0;
         ref_time_in    = stamp_ff;
         ovf_count_in   = '0;
      end

      if (cmd.fetch && pend_valid_ff) begin
         latched_in    = pend_stop_ff ? '0 : pend_speed_ff;
         pend_valid_in = 1'b0;
         pend_stop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff  <= RST_MIN_INTERVAL;
         timeout_limit_ff <= RST_TIMEOUT_LIMIT;
         speed_scale_ff   <= RST_SPEED_SCALE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL:  min_interval_ff  <= csr_data;
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_data[TIMEOUT_BITS-1:0];
            CSR_SPEED_SCALE:   speed_scale_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_high_ff  <= '0;
         ref_time_ff    <= '0;
         first_mode_ff  <= 1'b1;
         waiting_ff     <= 1'b0;
         ovf_count_ff   <= '0;
         pend_period_ff <= '0;
         pend_speed_ff  <= '0;
         pend_valid_ff  <= 1'b0;
         pend_stop_ff   <= 1'b0;
         latched_ff     <= '0;
      end else begin
         timer_high_ff  <= timer_high_in;
         ref_time_ff    <= ref_time_in;
         first_mode_ff  <= first_mode_in;
         waiting_ff     <= waiting_in;
         ovf_count_ff   <= ovf_count_in;
         pend_period_ff <= pend_period_in;
         pend_speed_ff  <= pend_speed_in;
         pend_valid_ff  <= pend_valid_in;
         pend_stop_ff   <= pend_stop_in;
         latched_ff     <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stamp_ff    <= stamp;
         interval_ff <= stamp - ref_time_ff;
      end
      if (cmd.evaluate) begin
         rem_ff     <= '0;
         quot_ff    <= speed_scale_ff;
         divisor_ff <= interval_ff;
      end else if (cmd.div_step) begin
         // a zero divisor always fits, so the quotient saturates to all ones
         if (!trial[DATA_BITS+1]) begin
            rem_ff <= trial[DATA_BITS-1:0];
         end else begin
            rem_ff <= {rem_ff[DATA_BITS-2:0], quot_ff[DATA_BITS-1]};
         end
         quot_ff <= {quot_ff[DATA_BITS-2:0], !trial[DATA_BITS+1]};
      end
      if (cmd.fetch) begin
         out_new_ff    <= pend_valid_ff;
         out_stop_ff   <= pend_valid_ff && pend_stop_ff;
         out_period_ff <= pend_valid_ff ? pend_period_ff : '0;
         out_speed_ff  <= pend_valid_ff ? pend_speed_ff : '0;
         out_held_ff   <= latched_in;
      end
   end

   assign new_value    = out_new_ff;
   assign is_stopped   = out_stop_ff;
   assign period_ticks = out_period_ff;
   assign speed        = out_speed_ff;
   assign held_speed   = out_held_ff;

endmodule

/* sv/pulse_period_tachometer_top.sv */
// Pulse-period tachometer.
// req channel: one beat per event; tuser carries the operation (fetch, timer
// overflow, sensor pulse), tdata the 16-bit timer capture used by pulses.
// rsp channel: one beat per fetch, none for overflows or pulses.
// csr channel: register writes (min_interval, timeout_limit, speed_scale),
// always ready; write only while the block is idle.
// Timing: a fetch or overflow does not occupy the block; a fetch beat appears
// on rsp the cycle after it is accepted. A pulse occupies the block through
// capture, compare, 32 steps of the radix-2 divider and commit when it yields a
// new period, and through capture and compare otherwise; req_tready is low meanwhile.
// A response waits in the output register while the receiver stalls; a
// request beat is still taken if the receiver takes the waiting
// response in the same cycle, otherwise req_tready stays low.
// Reset (synchronous) restores the register defaults, clears the timestamp,
// pending result and held speed, and re-arms first-pulse mode.
module pulse_period_tachometer_top #(
   parameter int TIMER_BITS = ppt_pkg::DEF_TIMER_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ppt_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // [15:0] timer_value
   input  logic [ppt_pkg::REQ_TUSER_BITS-1:0]   req_tuser,  // [1:0] operation
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] period_ticks, [63:32] speed, [95:64] held_speed
   output logic [ppt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output logic [ppt_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser,  // [0] new_value, [1] is_stopped
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ppt_pkg::DATA_BITS-1:0]        csr_data
);
   import ppt_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic                 new_value, is_stopped;
   logic [DATA_BITS-1:0] period_ticks, speed, held_speed;

   assign csr_ready = 1'b1;

   ppt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppt_dp #(
      .TIMER_BITS (TIMER_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .timer_value  (req_tdata[TIMER_VALUE_BITS-1:0]),
      .cmd          (cmd),
      .status       (status),
      .new_value    (new_value),
      .is_stopped   (is_stopped),
      .period_ticks (period_ticks),
      .speed        (speed),
      .held_speed   (held_speed)
   );

   assign rsp_tdata = {held_speed, speed, period_ticks};
   assign rsp_tuser = {is_stopped, new_value};

endmodule

/* sv/ppt_checker.sv */
`include "assert_macros.svh"

module ppt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [ppt_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ppt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic [ppt_pkg::RSP_TUSER_BITS-1:0] rsp_tuser
);
   import ppt_pkg::*;

   // a stalled response beat holds
   `PPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no pending result: period, speed and stop flag read zero
   `PPT_ASSERT(a_empty_fetch, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[2*DATA_BITS-1:0] == '0 && !rsp_tuser[1])

   // a stop report drops the held speed
   `PPT_ASSERT(a_stop_held, clock, reset, rsp_tvalid && rsp_tuser[1],
      rsp_tuser[0] && rsp_tdata[3*DATA_BITS-1:2*DATA_BITS] == '0)

   // a response only follows an accepted fetch beat
   `PPT_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_tvalid),
      $past(req_tvalid && req_tready && req_tuser == OP_FETCH))

endmodule

bind pulse_period_tachometer_top ppt_checker u_ppt_checker (.*);

/* tb/tach_reading_check.sv */
module tach_reading_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ppt_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [ppt_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ppt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic [ppt_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ppt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppt_pkg::DATA_BITS-1:0]      csr_data,
   output int                                 mismatch_count,
   output int                                 readings_due
);
   import ppt_pkg::*;

   typedef struct packed {
      logic                 new_value;
      logic [DATA_BITS-1:0] period;
      logic [DATA_BITS-1:0] speed;
      logic                 stopped;
      logic [DATA_BITS-1:0] held;
   } tach_reading_type;

   tach_reading_type expected_readings[$];

   // register copies
   logic [DATA_BITS-1:0]    min_interval;
   logic [TIMEOUT_BITS-1:0] timeout_limit;
   logic [DATA_BITS-1:0]    speed_scale;

   // measurement state
   logic [TIMER_HIGH_BITS-1:0] timer_high;
   logic [DATA_BITS-1:0]       ref_stamp;
   logic                       first_pulse;
   logic                       awaiting_pulse;
   logic [TIMEOUT_BITS-1:0]    overflows_seen;
   logic [DATA_BITS-1:0]       pend_period;
   logic [DATA_BITS-1:0]       pend_speed;
   logic                       pend_valid;
   logic                       pend_stop;
   logic [DATA_BITS-1:0]       held_speed;

   initial begin
      mismatch_count = 0;
      readings_due   = 0;
   end

   task automatic clear_tach_state();
      min_interval   = RST_MIN_INTERVAL;
      timeout_limit  = RST_TIMEOUT_LIMIT;
      speed_scale    = RST_SPEED_SCALE;
      timer_high     = '0;
      ref_stamp      = '0;
      first_pulse    = 1'b1;
      awaiting_pulse = 1'b0;
      overflows_seen = '0;
      pend_period    = '0;
      pend_speed     = '0;
      pend_valid     = 1'b0;
      pend_stop      = 1'b0;
      held_speed     = '0;
   endtask

   // Advance the tachometer by one event; a fetch queues the reading it returns.
   task automatic advance_tach(input logic [OP_BITS-1:0] op,
                               input logic [TIMER_VALUE_BITS-1:0] capture);
      logic [DATA_BITS-1:0] stamp;
      logic [DATA_BITS-1:0] interval;
      tach_reading_type     reading;
      stamp    = {timer_high, capture};
      interval = stamp - ref_stamp;
      reading  = '0;
      case (op)
         OP_OVERFLOW: begin
            timer_high = timer_high + TIMER_HIGH_BITS'(1);
            if (awaiting_pulse) begin
               overflows_seen = overflows_seen + TIMEOUT_BITS'(1);
               if (overflows_seen >= timeout_limit) begin
                  first_pulse    = 1'b1;
                  awaiting_pulse = 1'b0;
                  overflows_seen = '0;
                  pend_stop      = 1'b1;
                  pend_valid     = 1'b1;
               end
            end
         end
         OP_PULSE: begin
            if (first_pulse) begin
               first_pulse    = 1'b0;
               ref_stamp      = stamp;
               awaiting_pulse = 1'b1;
               overflows_seen = '0;
               pend_stop      = 1'b0;
            end else if (interval >= min_interval) begin
               pend_period = interval;
               if (interval == '0)
                  pend_speed = '1;
               else
                  pend_speed = speed_scale / interval;
               pend_valid     = 1'b1;
               pend_stop      = 1'b0;
               ref_stamp      = stamp;
               overflows_seen = '0;
            end
         end
         OP_FETCH: begin
            if (pend_valid) begin
               reading.new_value = 1'b1;
               reading.period    = pend_period;
               reading.speed     = pend_speed;
               reading.stopped   = pend_stop;
               held_speed        = pend_stop ? '0 : pend_speed;
               pend_valid        = 1'b0;
               pend_stop         = 1'b0;
            end
            reading.held = held_speed;
            expected_readings.push_back(reading);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input logic [DATA_BITS-1:0] want,
                              input logic [DATA_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      tach_reading_type want;
      if (reset) begin
         clear_tach_state();
         expected_readings.delete();
      end else begin
         // response beats always belong to fetches taken on earlier edges
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected reading beat, got tdata %0h tuser %0h",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("new_value", DATA_BITS'(want.new_value),
                           DATA_BITS'(rsp_tuser[0]));
               check_field("is_stopped", DATA_BITS'(want.stopped),
                           DATA_BITS'(rsp_tuser[1]));
               check_field("period_ticks", want.period, rsp_tdata[31:0]);
               check_field("speed", want.speed, rsp_tdata[63:32]);
               check_field("held_speed", want.held, rsp_tdata[95:64]);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_INTERVAL:  min_interval  = csr_data;
               CSR_TIMEOUT_LIMIT: timeout_limit = csr_data[TIMEOUT_BITS-1:0];
               CSR_SPEED_SCALE:   speed_scale   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            advance_tach(req_tuser, req_tdata[TIMER_VALUE_BITS-1:0]);
      end
      readings_due = expected_readings.size();
   end

endmodule

/* tb/tb_pulse_period_tachometer_top.sv */
module tb_pulse_period_tachometer_top;
   import ppt_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;   // covers a full pulse divide
   localparam int PHASE_EVENTS  = 272;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic [REQ_TUSER_BITS-1:0] req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DATA_BITS-1:0]      csr_data;

   int   mismatch_count;
   int   readings_due;
   int   quiet_cycles;
   bit   gaps_on;
   logic [TIMER_VALUE_BITS-1:0] timer_low;   // running timer count for pulse captures

   pulse_period_tachometer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tach_reading_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .readings_due   (readings_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_tready <= !(gaps_on && $urandom_range(99) < 24);
      end
   end

   // no beat on any channel for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_event(input logic [OP_BITS-1:0] op,
                             input logic [TIMER_VALUE_BITS-1:0] capture);
      while (gaps_on && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= capture;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_tach(input logic [DATA_BITS-1:0] min_ticks,
                               input logic [DATA_BITS-1:0] timeout,
                               input logic [DATA_BITS-1:0] scale);
      write_csr(CSR_MIN_INTERVAL, min_ticks);
      write_csr(CSR_TIMEOUT_LIMIT, timeout);
      write_csr(CSR_SPEED_SCALE, scale);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (readings_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly a plausible timeline: captures climb between overflows, with
   // some fully random captures and ignored codes mixed in.
   task automatic run_random_phase(input int n_events);
      int                          sent;
      int                          pick;
      logic [TIMER_VALUE_BITS:0]   next_low;
      logic [TIMER_VALUE_BITS-1:0] capture;
      sent = 0;
      while (sent < n_events) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            send_event(OP_FETCH, TIMER_VALUE_BITS'($urandom));
            sent++;
         end else if (pick < 33) begin
            send_event(OP_UNUSED, TIMER_VALUE_BITS'($urandom));
            sent++;
         end else if (pick < 55) begin
            send_event(OP_OVERFLOW, TIMER_VALUE_BITS'($urandom));
            timer_low = TIMER_VALUE_BITS'($urandom_range(0, 63));
            sent++;
         end else begin
            if ($urandom_range(4) == 0) begin
               capture = TIMER_VALUE_BITS'($urandom);
            end else begin
               if ($urandom_range(1))
                  next_low = {1'b0, timer_low} +
                             (TIMER_VALUE_BITS+1)'($urandom_range(0, 600));
               else
                  next_low = {1'b0, timer_low} +
                             (TIMER_VALUE_BITS+1)'($urandom_range(0, 16'hFFFF));
               capture = next_low[TIMER_VALUE_BITS] ? '1 : next_low[TIMER_VALUE_BITS-1:0];
            end
            timer_low = capture;
            send_event(OP_PULSE, capture);
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      gaps_on    = 1'b1;
      timer_low  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset register values: empty fetch, ignored code, wrap of the interval
      send_event(OP_FETCH, 16'h0000);
      send_event(OP_UNUSED, 16'hFFFF);
      send_event(OP_PULSE, 16'h0000);
      send_event(OP_OVERFLOW, 16'h0000);
      send_event(OP_OVERFLOW, 16'hFFFF);
      send_event(OP_PULSE, 16'hFFFF);
      send_event(OP_FETCH, 16'hFFFF);
      send_event(OP_PULSE, 16'h0010);
      send_event(OP_FETCH, 16'h0000);
      send_event(OP_PULSE, 16'h0020);   // shorter than the minimum
      send_event(OP_FETCH, 16'h0000);
      send_event(OP_UNUSED, 16'h0000);
      wait_drained();

      // zero minimum and zero timeout; upper data bits must be dropped
      program_tach(32'h0, 32'hFFFF_0000, 32'hFFFF_FFFF);
      send_event(OP_PULSE, 16'h1234);
      send_event(OP_PULSE, 16'h1234);   // zero interval saturates the speed
      send_event(OP_FETCH, 16'h0000);
      send_event(OP_OVERFLOW, 16'h0000);
      send_event(OP_FETCH, 16'h0000);   // stop report
      send_event(OP_PULSE, 16'h0001);
      send_event(OP_OVERFLOW, 16'h0000);
      send_event(OP_PULSE, 16'hABCD);   // first pulse drops the stop flag only
      send_event(OP_FETCH, 16'h0000);
      send_event(OP_FETCH, 16'h0000);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_tach(RST_MIN_INTERVAL, 32'(RST_TIMEOUT_LIMIT), RST_SPEED_SCALE);
            1: program_tach(32'd1, 32'd1, 32'd1);
            2: program_tach('1, 32'd65535, '1);
            3: program_tach($urandom_range(1, 2000), $urandom_range(1, 6), $urandom);
            4: program_tach($urandom, {16'($urandom), 16'($urandom_range(0, 3))},
                            $urandom);
            default: program_tach(32'd0, 32'd0, $urandom);
         endcase
         gaps_on = (phase != 3);
         run_random_phase(PHASE_EVENTS);
         wait_drained();
      end

      if (mismatch_count == 0 && readings_due == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
